// File: src/bsf_pkg.sv
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared types and constants for the byte stuffing framer with checksum.
// ----------------------------------------------------------------------------
`default_nettype none

package bsf_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int NUM_SLOTS = 5;
    localparam int CFG_IDX_W = 2;

    // output kinds; each kind also names its fixed slot in the result buffer
    localparam logic [KIND_W-1:0] KIND_START    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ESCAPE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CHECKSUM = 3'd3;
    localparam logic [KIND_W-1:0] KIND_END      = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_CODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CODE = 2'd2;

    // configuration reset values
    localparam logic [BYTE_W-1:0] START_CODE_RST  = 8'h02;
    localparam logic [BYTE_W-1:0] END_CODE_RST    = 8'h03;
    localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'h10;

    // current code values
    typedef struct packed {
        logic [BYTE_W-1:0] start_code;
        logic [BYTE_W-1:0] end_code;
        logic [BYTE_W-1:0] escape_code;
    } codes_t;

    // one encoded item: present slots and the byte of each slot
    typedef struct packed {
        logic                           valid;
        logic [NUM_SLOTS-1:0]           mask;
        logic [NUM_SLOTS-1:0][BYTE_W-1:0] bytes;
    } slot_load_t;

endpackage

`default_nettype wire

// File: src/bsf_encoder.sv
// ----------------------------------------------------------------------------
// bsf_encoder
// Input register, frame state and running sum; turns one message byte into
// the set of framed output bytes it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module bsf_encoder
    import bsf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] in_data,
    input  wire logic              in_last,
    input  wire codes_t            codes,
    output slot_load_t             load,
    input  wire logic              load_ready
);

    logic              item_valid_reg;
    logic [BYTE_W-1:0] item_data_reg;
    logic              item_last_reg;
    logic              in_frame_reg;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] sum_next;
    logic              is_special;
    logic              load_fire;

    assign load_fire = item_valid_reg && load_ready;
    assign in_ready  = !item_valid_reg || load_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_data_reg <= in_data;
            item_last_reg <= in_last;
        end
    end

    // encode the held item
    assign sum_next   = sum_reg + item_data_reg;
    assign is_special = (item_data_reg == codes.start_code)
                     || (item_data_reg == codes.end_code)
                     || (item_data_reg == codes.escape_code);

    always_comb
    begin
        load.valid = item_valid_reg;
        load.mask  = '0;
        load.bytes = '0;
        load.mask[KIND_START]     = !in_frame_reg;
        load.mask[KIND_ESCAPE]    = is_special;
        load.mask[KIND_PAYLOAD]   = 1'b1;
        load.mask[KIND_CHECKSUM]  = item_last_reg;
        load.mask[KIND_END]       = item_last_reg;
        load.bytes[KIND_START]    = codes.start_code;
        load.bytes[KIND_ESCAPE]   = codes.escape_code;
        load.bytes[KIND_PAYLOAD]  = item_data_reg;
        load.bytes[KIND_CHECKSUM] = ~sum_next;
        load.bytes[KIND_END]      = codes.end_code;
    end

    // frame state advances when the item moves to the result buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            sum_reg      <= '0;
        end
        else if (load_fire)
        begin
            in_frame_reg <= !item_last_reg;
            sum_reg      <= item_last_reg ? '0 : sum_next;
        end
    end

endmodule

`default_nettype wire

// File: src/bsf_serializer.sv
// ----------------------------------------------------------------------------
// bsf_serializer
// Result buffer that sends the present slots of one encoded item, lowest
// slot first, one byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module bsf_serializer
    import bsf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire slot_load_t        load,
    output logic                   load_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [BYTE_W-1:0]      out_byte,
    output logic [KIND_W-1:0]      out_kind,
    output logic                   out_last
);

    logic [NUM_SLOTS-1:0]             mask_reg;
    logic [NUM_SLOTS-1:0]             mask_next;
    logic [NUM_SLOTS-1:0][BYTE_W-1:0] bytes_reg;
    logic [NUM_SLOTS-1:0]             rest;
    logic [KIND_W-1:0]                sel;

    // lowest present slot
    always_comb
    begin
        sel = KIND_END;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = KIND_W'(i);
            end
        end
    end

    assign rest       = mask_reg & (mask_reg - NUM_SLOTS'(1));
    assign out_valid  = |mask_reg;
    assign out_last   = out_valid && (rest == '0);
    assign out_kind   = sel;
    assign out_byte   = bytes_reg[sel];
    assign load_ready = !out_valid || (out_ready && out_last);

    // drop the sent slot, or take the next item
    always_comb
    begin
        mask_next = mask_reg;
        if (load_ready)
        begin
            mask_next = load.valid ? load.mask : '0;
        end
        else if (out_ready)
        begin
            mask_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load.valid)
        begin
            bytes_reg <= load.bytes;
        end
    end

endmodule

`default_nettype wire

// File: src/byte_stuff_framer_checksum.sv
// ----------------------------------------------------------------------------
// byte_stuff_framer_checksum
// Frames a byte stream with start/end codes, escapes special payload bytes
// and appends the one's complement of the 8-bit payload sum.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries message bytes; s_tlast marks the last byte of a message.
//   m_* carries the framed stream: start code, escape, payload, checksum,
//   end code, with the kind on m_tuser and m_tlast on the final byte caused
//   by one message byte.
//   cfg_* writes the start, end and escape codes (index 0, 1, 2; index 3
//   is ignored). cfg_ready is always high; write only while idle.
// Timing:
//   a message byte is held in the input register, then its output
//   bytes leave the result buffer one per cycle while m_tready is high.
//   Each message byte causes 1 to 5 output bytes, sent one at a time
//   through the single byte-wide output port; a new
//   message byte is taken while the previous one is still being sent.
// Reset: no frame open, sum zero, codes back to 0x02, 0x03, 0x10.
// Stall: with m_tready low the result buffer holds and, once the input
//   register is full too, s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stuff_framer_checksum
    import bsf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // message input
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
    input  wire logic                 s_tlast,   // last_in
    // framed output
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [BYTE_W-1:0]         m_tdata,   // [7:0] out_byte
    output logic [KIND_W-1:0]         m_tuser,   // [2:0] out_kind
    output logic                      m_tlast,   // out_last
    // configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data
);

    codes_t     codes_reg;
    slot_load_t load;
    logic       load_ready;

    // code registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.start_code  <= START_CODE_RST;
            codes_reg.end_code    <= END_CODE_RST;
            codes_reg.escape_code <= ESCAPE_CODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START_CODE:  codes_reg.start_code  <= cfg_data;
                REG_END_CODE:    codes_reg.end_code    <= cfg_data;
                REG_ESCAPE_CODE: codes_reg.escape_code <= cfg_data;
                default:         ;
            endcase
        end
    end

    bsf_encoder u_encoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .in_last    (s_tlast),
        .codes      (codes_reg),
        .load       (load),
        .load_ready (load_ready)
    );

    bsf_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .load_ready (load_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_kind   (m_tuser),
        .out_last   (m_tlast)
    );

    // the end code always closes the output of its message byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_END) |-> m_tlast)
        else $error("end code not marked last");

    // escape and checksum are always followed by another byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_ESCAPE || m_tuser == KIND_CHECKSUM))
        |-> !m_tlast)
        else $error("escape or checksum marked last");

    // a sent checksum is followed by the end code
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tuser == KIND_CHECKSUM)
        |=> (m_tvalid && m_tuser == KIND_END))
        else $error("checksum not followed by end code");

    // the result buffer only takes an item when its last byte leaves
    assert property (@(posedge clk) disable iff (!rst_n)
        (load.valid && load_ready) |-> (!m_tvalid || (m_tready && m_tlast)))
        else $error("result buffer overwritten");

endmodule

`default_nettype wire

// File: verif/tb_byte_stuff_framer_checksum.sv
// ----------------------------------------------------------------------------
// tb_byte_stuff_framer_checksum
// Self-checking bench for the byte stuffing framer. Message bytes and code
// register writes come from one queue. A built-in framing predictor turns
// each accepted byte into the output bytes it should cause: start code,
// escape, payload, checksum and end code. Every output transfer is checked
// field by field against them. Both stream sides idle at random, and the
// output side holds off for long stretches so the input side backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_byte_stuff_framer_checksum;

    import bsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // index past the last register, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic {ENT_BYTE, ENT_WRITE} entry_kind_t;
    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_EVERY_THIRD} rx_mode_t;

    // one queued stimulus entry: a message byte or a code register write
    typedef struct {
        entry_kind_t          kind;
        logic [BYTE_W-1:0]    data;
        logic                 last;
        logic [CFG_IDX_W-1:0] index;
    } tx_entry_t;

    // one byte of the framed stream
    typedef struct {
        logic [BYTE_W-1:0] value;
        logic [KIND_W-1:0] kind;
        logic              last;
    } framed_byte_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [BYTE_W-1:0]    m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data = '0;

    tx_entry_t    tx_q[$];
    framed_byte_t framed_q[$];

    // predictor state
    codes_t            code_regs;
    logic              frame_open;
    logic [BYTE_W-1:0] payload_sum;

    int mismatches  = 0;
    int bytes_taken = 0;

    // transfers seen at the last rising edge, used by the drivers
    logic in_xfer  = 1'b0;
    logic cfg_xfer = 1'b0;

    int burst_left = 0;
    int gap_left   = 0;

    rx_mode_t rx_mode      = RX_ALWAYS;
    int       mode_left    = 0;
    int       rx_cycle     = 0;
    int       holdoff_left = 0;
    int       holdoff_mark = 30;

    byte_stuff_framer_checksum u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #400000;
        $display("tb_byte_stuff_framer_checksum NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] mismatch %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endtask

    task automatic add_byte(input logic [BYTE_W-1:0] b, input logic last);
        tx_entry_t e;
        e.kind  = ENT_BYTE;
        e.data  = b;
        e.last  = last;
        e.index = '0;
        tx_q.push_back(e);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] v);
        tx_entry_t e;
        e.kind  = ENT_WRITE;
        e.data  = v;
        e.last  = 1'b0;
        e.index = idx;
        tx_q.push_back(e);
    endtask

    // code register write as the block should take it
    task automatic apply_code_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] v);
        case (idx)
            REG_START_CODE:  code_regs.start_code  = v;
            REG_END_CODE:    code_regs.end_code    = v;
            REG_ESCAPE_CODE: code_regs.escape_code = v;
            default: ;
        endcase
    endtask

    // framing predictor: queue the output bytes caused by one message byte
    task automatic frame_byte(input logic [BYTE_W-1:0] b, input logic last);
        framed_byte_t outs[$];
        framed_byte_t fb;
        if (!frame_open)
        begin
            fb = '{code_regs.start_code, KIND_START, 1'b0};
            outs.push_back(fb);
            frame_open = 1'b1;
        end
        if (b == code_regs.start_code || b == code_regs.end_code || b == code_regs.escape_code)
        begin
            fb = '{code_regs.escape_code, KIND_ESCAPE, 1'b0};
            outs.push_back(fb);
        end
        fb = '{b, KIND_PAYLOAD, 1'b0};
        outs.push_back(fb);
        payload_sum = payload_sum + b;
        // checksum goes out raw, never escaped
        if (last)
        begin
            fb = '{~payload_sum, KIND_CHECKSUM, 1'b0};
            outs.push_back(fb);
            fb = '{code_regs.end_code, KIND_END, 1'b0};
            outs.push_back(fb);
            frame_open  = 1'b0;
            payload_sum = '0;
        end
        outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i])
            framed_q.push_back(outs[i]);
    endtask

    // monitor: checks output transfers, predicts on input transfers
    always @(posedge clk)
    begin
        framed_byte_t want;
        in_xfer  <= rst_n && s_tvalid && s_tready;
        cfg_xfer <= rst_n && cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (framed_q.size() == 0)
                    report_mismatch("unexpected output transfer", 0, 32'(m_tdata));
                else
                begin
                    want = framed_q.pop_front();
                    if (m_tdata !== want.value)
                        report_mismatch("out_byte", 32'(want.value), 32'(m_tdata));
                    if (m_tuser !== want.kind)
                        report_mismatch("out_kind", 32'(want.kind), 32'(m_tuser));
                    if (m_tlast !== want.last)
                        report_mismatch("out_last", 32'(want.last), 32'(m_tlast));
                end
            end
            if (cfg_valid && cfg_ready)
                apply_code_write(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
            begin
                frame_byte(s_tdata, s_tlast);
                bytes_taken++;
            end
        end
    end

    // input driver: bursts of message bytes, register writes only when drained
    always @(negedge clk)
    begin
        tx_entry_t head;
        logic      next_s;
        logic      next_c;
        if (rst_n)
        begin
            next_s = s_tvalid;
            next_c = cfg_valid;
            if (in_xfer)
            begin
                void'(tx_q.pop_front());
                next_s = 1'b0;
            end
            if (cfg_xfer)
            begin
                void'(tx_q.pop_front());
                next_c = 1'b0;
            end
            if (!next_s && !next_c && tx_q.size() > 0)
            begin
                head = tx_q[0];
                if (head.kind == ENT_WRITE)
                begin
                    if (framed_q.size() == 0)
                    begin
                        next_c = 1'b1;
                        cfg_index <= head.index;
                        cfg_data  <= head.data;
                    end
                end
                else if (gap_left > 0)
                    gap_left--;
                else
                begin
                    next_s = 1'b1;
                    s_tdata <= head.data;
                    s_tlast <= head.last;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
            end
            s_tvalid  <= next_s;
            cfg_valid <= next_c;
        end
    end

    // output side ready: random modes plus a few long hold-offs
    always @(negedge clk)
    begin
        logic ready;
        if (rst_n)
        begin
            rx_cycle++;
            ready = 1'b1;
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                ready = 1'b0;
            end
            else if (bytes_taken >= holdoff_mark)
            begin
                holdoff_left = $urandom_range(60, 100);
                holdoff_mark = holdoff_mark + 90;
                ready = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 60);
                end
                else
                    mode_left--;
                case (rx_mode)
                    RX_ALWAYS:      ready = 1'b1;
                    RX_COIN:        ready = 1'($urandom_range(0, 1));
                    RX_MOSTLY:      ready = ($urandom_range(0, 3) != 0);
                    RX_EVERY_THIRD: ready = (rx_cycle % 3 != 0);
                endcase
            end
            m_tready <= ready;
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        logic [BYTE_W-1:0] c_start;
        logic [BYTE_W-1:0] c_end;
        logic [BYTE_W-1:0] c_esc;
        logic [BYTE_W-1:0] b;
        int                msg_len;
        int                pos;
        int                pick;

        code_regs.start_code  = START_CODE_RST;
        code_regs.end_code    = END_CODE_RST;
        code_regs.escape_code = ESCAPE_CODE_RST;
        frame_open  = 1'b0;
        payload_sum = '0;

        // single-byte message with the reset codes
        add_byte(8'h41, 1'b1);
        // extremes and every code as payload
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(START_CODE_RST, 1'b0);
        add_byte(END_CODE_RST, 1'b0);
        add_byte(ESCAPE_CODE_RST, 1'b0);
        add_byte(8'h55, 1'b1);
        // checksum comes out equal to the start code
        add_byte(8'hFD, 1'b1);
        // codes rewritten to extremes while a frame is open
        add_byte(8'h20, 1'b0);
        add_write(REG_START_CODE, 8'h00);
        add_write(REG_END_CODE, 8'hFF);
        add_write(REG_ESCAPE_CODE, 8'h80);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(START_CODE_RST, 1'b1);
        // all three codes equal
        add_write(REG_START_CODE, 8'hAA);
        add_write(REG_END_CODE, 8'hAA);
        add_write(REG_ESCAPE_CODE, 8'hAA);
        add_byte(8'hAA, 1'b0);
        add_byte(8'h55, 1'b1);
        // write to the unused index is dropped
        add_write(REG_UNUSED, 8'h12);
        add_byte(8'h12, 1'b1);

        // random phases, each with its own code setting
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    c_start = BYTE_W'($urandom_range(0, 255));
                    c_end   = BYTE_W'($urandom_range(0, 255));
                    c_esc   = BYTE_W'($urandom_range(0, 255));
                end
                1:
                begin
                    c_start = 8'h00;
                    c_end   = 8'hFF;
                    c_esc   = BYTE_W'($urandom_range(0, 255));
                end
                2:
                begin
                    c_start = BYTE_W'($urandom_range(0, 255));
                    c_end   = ($urandom_range(0, 1) == 0) ? c_start : 8'hFF;
                    c_esc   = c_start;
                end
                default:
                begin
                    c_start = START_CODE_RST;
                    c_end   = END_CODE_RST;
                    c_esc   = ESCAPE_CODE_RST;
                end
            endcase
            add_write(REG_START_CODE, c_start);
            add_write(REG_END_CODE, c_end);
            add_write(REG_ESCAPE_CODE, c_esc);
            if (ph % 2 == 1)
                add_write(REG_UNUSED, BYTE_W'($urandom_range(0, 255)));

            // messages of mostly short length, payload often hitting a code
            pos = 0;
            msg_len = $urandom_range(1, 6);
            for (int n = 0; n < 26; n++)
            begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0:       b = c_start;
                    1:       b = c_end;
                    2:       b = c_esc;
                    default: b = BYTE_W'($urandom_range(0, 255));
                endcase
                pos++;
                add_byte(b, pos >= msg_len);
                if (pos >= msg_len)
                begin
                    pos = 0;
                    msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
                                                          : $urandom_range(1, 6);
                end
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (tx_q.size() == 0 && framed_q.size() == 0);
        repeat (12) @(posedge clk);
        if (mismatches == 0 && framed_q.size() == 0)
            $display("tb_byte_stuff_framer_checksum OK");
        else
            $display("tb_byte_stuff_framer_checksum NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
